// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned FIELD_W   = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] a_num;
    logic [FIELD_W-1:0] a_den;
    logic [FIELD_W-1:0] b_num;
    logic [FIELD_W-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] res_num;
    logic [FIELD_W-1:0] res_den;
    status_e            status;
  } out_t;

endpackage

// ===== rtl/rau_gcd.sv =====
// Binary gcd unit: one shift or subtract step per cycle.
module rau_gcd #(
  parameter int unsigned DW = 2 * rau_pkg::WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] res_o
);

  localparam int unsigned KW = $clog2(DW + 1);
  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_RUN   = 2'd1;
  localparam logic [1:0] P_SHIFT = 2'd2;

  logic [1:0]    phase_q, phase_d;
  logic [DW-1:0] x_q, x_d, y_q, y_d;
  logic [KW-1:0] k_q, k_d;
  logic          done_q, done_d;

  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    y_d     = y_q;
    k_d     = k_q;
    done_d  = 1'b0;
    case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          x_d     = a_i;
          y_d     = b_i;
          k_d     = '0;
          phase_d = P_RUN;
        end
      end
      P_RUN: begin
        if (x_q == '0 || y_q == '0) begin
          x_d     = x_q | y_q;
          phase_d = P_SHIFT;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      P_SHIFT: begin
        if (k_q == '0) begin
          done_d  = 1'b1;
          phase_d = P_IDLE;
        end else begin
          x_d = x_q << 1;
          k_d = k_q - KW'(1);
        end
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    k_q <= k_d;
  end

  assign done_o = done_q;
  assign res_o  = x_q;

endmodule

// ===== rtl/rau_div.sv =====
// Restoring divider: one quotient bit per cycle.
module rau_div #(
  parameter int unsigned DW = 2 * rau_pkg::WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d, done_q, done_d;
  logic [DW-1:0] q_q, q_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   trial;

  assign trial = {rem_q, q_q[DW-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    q_d    = q_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    if (!busy_q) begin
      if (start_i) begin
        q_d    = num_i;
        rem_d  = '0;
        dvs_d  = den_i;
        cnt_d  = CW'(DW - 1);
        busy_d = 1'b1;
      end
    end else begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DW'(trial - {1'b0, dvs_q});
        q_d   = {q_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        q_d   = {q_q[DW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

// ===== rtl/rational_arith_unit.sv =====
// Top level: sequencer, multiplier and output register of the rational arithmetic unit.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    rau_pkg::in_t
//   out      output     out_valid_o / out_ready_i  rau_pkg::out_t
//
// The time an item takes is set by the binary gcd unit (one shift or subtract
// a cycle, run once or twice) and the divider (run two or four times); an item
// with a zero denominator or divisor skips both.
// The block takes one item at a time; a finished result waits in the output
// register while the next item is accepted. Reset is asynchronous, active low.
module rational_arith_unit #(
  parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rau_pkg::out_t out_data_o
);

  localparam int unsigned DW = 2 * WIDTH;
  localparam int unsigned FW = rau_pkg::FIELD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GCD1 = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_DIV2 = 4'd3;
  localparam logic [3:0] S_MUL0 = 4'd4;
  localparam logic [3:0] S_MUL1 = 4'd5;
  localparam logic [3:0] S_MUL2 = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_GCD2 = 4'd8;
  localparam logic [3:0] S_DIV3 = 4'd9;
  localparam logic [3:0] S_DIV4 = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]       state_q, state_d;
  logic             go_q, go_d;
  rau_pkg::op_e     op_q, op_d;
  logic [WIDTH-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic             an_s_q, an_s_d, ad_s_q, ad_s_d, bn_s_q, bn_s_d, bd_s_q, bd_s_d;
  logic [WIDTH-1:0] q1_q, q1_d, q2_q, q2_d;
  logic [DW-1:0]    t_q, t_d, n_q, n_d, d_q, d_d, g_q, g_d;
  logic             n_s_q, n_s_d, d_s_q, d_s_d, err_q, err_d;
  logic             out_valid_q, out_valid_d;
  rau_pkg::out_t    out_q, out_d;

  logic [WIDTH-1:0] raw_an, raw_ad, raw_bn, raw_bd;
  logic [WIDTH-1:0] mag_an, mag_ad, mag_bn, mag_bd;
  logic             dec_err, is_mul;
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [DW-1:0]    prod;
  logic             gcd_start, gcd_done, div_start, div_done;
  logic [DW-1:0]    gcd_a, gcd_b, gcd_res, div_n, div_d, div_q;
  logic             s1, s2, n_fit, d_fit;
  logic [DW-1:0]    lim;

  assign raw_an = in_data_i.a_num[WIDTH-1:0];
  assign raw_ad = in_data_i.a_den[WIDTH-1:0];
  assign raw_bn = in_data_i.b_num[WIDTH-1:0];
  assign raw_bd = in_data_i.b_den[WIDTH-1:0];
  assign mag_an = raw_an[WIDTH-1] ? (~raw_an + WIDTH'(1)) : raw_an;
  assign mag_ad = raw_ad[WIDTH-1] ? (~raw_ad + WIDTH'(1)) : raw_ad;
  assign mag_bn = raw_bn[WIDTH-1] ? (~raw_bn + WIDTH'(1)) : raw_bn;
  assign mag_bd = raw_bd[WIDTH-1] ? (~raw_bd + WIDTH'(1)) : raw_bd;
  assign dec_err = (raw_ad == '0) || (raw_bd == '0) ||
                   ((in_data_i.op == rau_pkg::OP_DIV) && (raw_bn == '0));
  assign is_mul = (op_q == rau_pkg::OP_MUL) || (op_q == rau_pkg::OP_DIV);

  assign prod = mul_a * mul_b;

  assign s1  = an_s_q ^ ad_s_q;
  assign s2  = bn_s_q ^ bd_s_q ^ (op_q == rau_pkg::OP_SUB);
  assign lim = DW'(1) << (WIDTH - 1);
  assign n_fit = n_s_q ? (n_q <= lim) : (n_q < lim);
  assign d_fit = d_s_q ? (d_q <= lim) : (d_q < lim);

  always_comb begin
    mul_a = an_q;
    mul_b = bn_q;
    case (state_q)
      S_MUL0: begin
        mul_a = an_q;
        mul_b = is_mul ? bn_q : q1_q;
      end
      S_MUL1: begin
        mul_a = is_mul ? ad_q : bn_q;
        mul_b = is_mul ? bd_q : q2_q;
      end
      S_MUL2: begin
        mul_a = ad_q;
        mul_b = q1_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bn_q;
      end
    endcase
  end

  always_comb begin
    gcd_a = (state_q == S_GCD1) ? DW'(ad_q) : n_q;
    gcd_b = (state_q == S_GCD1) ? DW'(bd_q) : d_q;
    gcd_start = go_q && ((state_q == S_GCD1) || (state_q == S_GCD2));
    div_start = go_q && ((state_q == S_DIV1) || (state_q == S_DIV2) ||
                         (state_q == S_DIV3) || (state_q == S_DIV4));
    div_d = g_q;
    case (state_q)
      S_DIV1:  div_n = DW'(bd_q);
      S_DIV2:  div_n = DW'(ad_q);
      S_DIV3:  div_n = n_q;
      default: div_n = d_q;
    endcase
  end

  rau_gcd #(.DW(DW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (gcd_a),
    .b_i     (gcd_b),
    .done_o  (gcd_done),
    .res_o   (gcd_res)
  );

  rau_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    op_d    = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    an_s_d = an_s_q; ad_s_d = ad_s_q; bn_s_d = bn_s_q; bd_s_d = bd_s_q;
    q1_d = q1_q; q2_d = q2_q;
    t_d = t_q; n_d = n_q; d_d = d_q; g_d = g_q;
    n_s_d = n_s_q; d_s_d = d_s_q; err_d = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_data_i.op;
          an_d   = mag_an;
          an_s_d = raw_an[WIDTH-1];
          ad_d   = mag_ad;
          ad_s_d = raw_ad[WIDTH-1];
          err_d  = dec_err;
          if (in_data_i.op == rau_pkg::OP_DIV) begin
            bn_d = mag_bd; bn_s_d = raw_bd[WIDTH-1];
            bd_d = mag_bn; bd_s_d = raw_bn[WIDTH-1];
          end else begin
            bn_d = mag_bn; bn_s_d = raw_bn[WIDTH-1];
            bd_d = mag_bd; bd_s_d = raw_bd[WIDTH-1];
          end
          if (dec_err) begin
            state_d = S_FIN;
          end else if ((in_data_i.op == rau_pkg::OP_ADD) ||
                       (in_data_i.op == rau_pkg::OP_SUB)) begin
            state_d = S_GCD1;
            go_d    = 1'b1;
          end else begin
            state_d = S_MUL0;
          end
        end
      end
      S_GCD1: begin
        if (gcd_done) begin
          g_d = gcd_res; state_d = S_DIV1; go_d = 1'b1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          q1_d = div_q[WIDTH-1:0]; state_d = S_DIV2; go_d = 1'b1;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          q2_d = div_q[WIDTH-1:0]; state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        if (is_mul) begin
          n_d   = prod;
          n_s_d = an_s_q ^ bn_s_q;
        end else begin
          t_d = prod;
        end
        state_d = S_MUL1;
      end
      S_MUL1: begin
        if (is_mul) begin
          d_d     = prod;
          d_s_d   = ad_s_q ^ bd_s_q;
          state_d = S_GCD2;
          go_d    = 1'b1;
        end else begin
          n_d     = prod;
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        d_d     = prod;
        d_s_d   = 1'b0;
        state_d = S_SUM;
      end
      S_SUM: begin
        if (s1 == s2) begin
          n_d = t_q + n_q; n_s_d = s1;
        end else if (t_q >= n_q) begin
          n_d = t_q - n_q; n_s_d = s1;
        end else begin
          n_d = n_q - t_q; n_s_d = s2;
        end
        state_d = S_GCD2;
        go_d    = 1'b1;
      end
      S_GCD2: begin
        if (gcd_done) begin
          g_d = gcd_res; state_d = S_DIV3; go_d = 1'b1;
        end
      end
      S_DIV3: begin
        if (div_done) begin
          n_d = div_q; state_d = S_DIV4; go_d = 1'b1;
        end
      end
      S_DIV4: begin
        if (div_done) begin
          d_d = div_q; state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (err_q) begin
            out_d = '{res_num: '0, res_den: '0, status: rau_pkg::ST_ZERO};
          end else if (!n_fit || !d_fit) begin
            out_d = '{res_num: '0, res_den: '0, status: rau_pkg::ST_OVF};
          end else begin
            out_d.res_num = n_s_q ? (FW'(0) - FW'(n_q)) : FW'(n_q);
            out_d.res_den = d_s_q ? (FW'(0) - FW'(d_q)) : FW'(d_q);
            out_d.status  = rau_pkg::ST_OK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    an_s_q <= an_s_d; ad_s_q <= ad_s_d; bn_s_q <= bn_s_d; bd_s_q <= bd_s_d;
    q1_q <= q1_d; q2_q <= q2_d;
    t_q <= t_d; n_q <= n_d; d_q <= d_d; g_q <= g_d;
    n_s_q <= n_s_d; d_s_q <= d_s_d; err_q <= err_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_gcd_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcd_done |-> (state_q == S_GCD1) || (state_q == S_GCD2))
    else $error("gcd result arrived outside a gcd step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV1) || (state_q == S_DIV2) ||
                 (state_q == S_DIV3) || (state_q == S_DIV4))
    else $error("quotient arrived outside a divide step");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted beat did not start the sequencer");

  a_ok_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == rau_pkg::ST_OK)) |-> (out_data_o.res_den != '0))
    else $error("good result carries a zero denominator");

endmodule

// ===== bench/rational_arith_unit_test.sv =====
// Testbench for the rational arithmetic unit: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module rational_arith_unit_test;

  localparam int W = 32;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  rau_pkg::in_t   in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  rau_pkg::out_t  out_data_o;

  rau_pkg::in_t   pending_beats[$];
  rau_pkg::out_t  expected_results[$];
  int    errors = 0;
  bit    stim_done = 1'b0;
  int    send_gap = 0;
  int    recv_gap = 0;
  int    hold_cycles = 0;

  rational_arith_unit #(.WIDTH(W)) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] magnitude(logic [31:0] v);
    return v[31] ? 64'(-$signed({v[31], v})) : 64'(v);
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [31:0] to_field(bit neg, logic [63:0] mag);
    logic [63:0] v;
    v = neg ? -mag : mag;
    return v[31:0];
  endfunction

  function automatic rau_pkg::out_t fraction_result(rau_pkg::in_t x);
    rau_pkg::out_t r;
    logic [63:0] an, ad, bn, bd, l, m1, m2, nm, dm, g, n2, d2;
    bit s1, s2, nneg, dneg, n2s, d2s;
    r = '0;
    an = magnitude(x.a_num);
    ad = magnitude(x.a_den);
    bn = magnitude(x.b_num);
    bd = magnitude(x.b_den);
    if (ad == 0 || bd == 0 || (x.op == rau_pkg::OP_DIV && bn == 0)) begin
      r.status = rau_pkg::ST_ZERO;
      return r;
    end
    if (x.op == rau_pkg::OP_ADD || x.op == rau_pkg::OP_SUB) begin
      l = ad / gcd64(ad, bd) * bd;
      s1 = x.a_num[31] != x.a_den[31];
      m1 = (l / ad) * an;
      s2 = (x.b_num[31] != x.b_den[31]) != (x.op == rau_pkg::OP_SUB);
      m2 = (l / bd) * bn;
      if (m1 == 0) s1 = 1'b0;
      if (m2 == 0) s2 = 1'b0;
      if (s1 == s2) begin
        nneg = s1;
        nm = m1 + m2;
      end else if (m1 >= m2) begin
        nneg = s1;
        nm = m1 - m2;
      end else begin
        nneg = s2;
        nm = m2 - m1;
      end
      if (nm == 0) nneg = 1'b0;
      dneg = 1'b0;
      dm = l;
    end else begin
      n2 = (x.op == rau_pkg::OP_MUL) ? bn : bd;
      d2 = (x.op == rau_pkg::OP_MUL) ? bd : bn;
      n2s = (x.op == rau_pkg::OP_MUL) ? x.b_num[31] : x.b_den[31];
      d2s = (x.op == rau_pkg::OP_MUL) ? x.b_den[31] : x.b_num[31];
      nm = an * n2;
      nneg = (nm != 0) && (x.a_num[31] != n2s);
      dm = ad * d2;
      dneg = x.a_den[31] != d2s;
    end
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if ((nneg ? nm > 64'h8000_0000 : nm >= 64'h8000_0000) ||
        (dneg ? dm > 64'h8000_0000 : dm >= 64'h8000_0000)) begin
      r.status = rau_pkg::ST_OVF;
      return r;
    end
    r.res_num = to_field(nneg, nm);
    r.res_den = to_field(dneg, dm);
    r.status = rau_pkg::ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'($signed($urandom_range(0, 40)) - 20);
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom;
      3: return 32'($signed($urandom_range(0, 131070)) - 65535);
      4: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(1, 64)) * ($urandom_range(0, 1) ? 1 : -1));
    endcase
  endfunction

  function automatic rau_pkg::in_t make_beat(rau_pkg::op_e op, logic [31:0] an,
                                             logic [31:0] ad, logic [31:0] bn,
                                             logic [31:0] bd);
    rau_pkg::in_t b;
    b.op = op;
    b.a_num = an;
    b.a_den = ad;
    b.b_num = bn;
    b.b_den = bd;
    return b;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    rau_pkg::in_t b;
    pending_beats.push_back(make_beat(rau_pkg::OP_ADD, 1, 2, 1, 3));
    pending_beats.push_back(make_beat(rau_pkg::OP_SUB, 1, 2, 1, 2));
    pending_beats.push_back(make_beat(rau_pkg::OP_MUL, -3, 4, 2, -9));
    pending_beats.push_back(make_beat(rau_pkg::OP_DIV, 5, -6, -10, 3));
    pending_beats.push_back(make_beat(rau_pkg::OP_ADD, 1, 0, 1, 3));
    pending_beats.push_back(make_beat(rau_pkg::OP_MUL, 1, 3, 1, 0));
    pending_beats.push_back(make_beat(rau_pkg::OP_DIV, 1, 3, 0, 7));
    pending_beats.push_back(make_beat(rau_pkg::OP_DIV, 0, 3, 0, 0));
    pending_beats.push_back(make_beat(rau_pkg::OP_MUL, 0, -5, 7, 3));
    pending_beats.push_back(make_beat(rau_pkg::OP_SUB, 0, -5, 0, 3));
    pending_beats.push_back(make_beat(rau_pkg::OP_MUL, 32'h7fff_ffff, 1,
                                      32'h7fff_ffff, 1));
    pending_beats.push_back(make_beat(rau_pkg::OP_MUL, 32'h8000_0000, 1, 1, 1));
    pending_beats.push_back(make_beat(rau_pkg::OP_MUL, 32'h8000_0000, 1, -1, 1));
    pending_beats.push_back(make_beat(rau_pkg::OP_DIV, 1, 32'h8000_0000, 1, 1));
    pending_beats.push_back(make_beat(rau_pkg::OP_DIV, 1, 32'h8000_0000, -1, 1));
    pending_beats.push_back(make_beat(rau_pkg::OP_ADD, 32'h7fff_ffff, 1,
                                      32'h7fff_ffff, 1));
    pending_beats.push_back(make_beat(rau_pkg::OP_SUB, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000, 32'h7fff_ffff));
    pending_beats.push_back(make_beat(rau_pkg::OP_ADD, 1, 32'h7fff_ffff, 1,
                                      32'h7fff_fffe));
    pending_beats.push_back(make_beat(rau_pkg::OP_DIV, -4, -6, -2, -3));
    pending_beats.push_back(make_beat(rau_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff,
                                      32'hffff_ffff, 32'hffff_ffff));
    for (int i = 0; i < 1330; i++) begin
      b.op = rau_pkg::op_e'($urandom_range(0, 3));
      b.a_num = rand_operand();
      b.a_den = rand_operand();
      b.b_num = rand_operand();
      b.b_den = rand_operand();
      if ($urandom_range(0, 19) != 0 && b.a_den == 0) b.a_den = 1;
      if ($urandom_range(0, 19) != 0 && b.b_den == 0) b.b_den = -1;
      pending_beats.push_back(b);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(fraction_result(in_data_i));
        send_gap = pick_gap();
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0 || pending_beats.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
          if (pending_beats.size() == 0 && !(in_valid_i && !in_ready_o)) stim_done = 1'b1;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_beats.pop_front();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_data_o);
          errors++;
        end else begin
          rau_pkg::out_t e;
          e = expected_results.pop_front();
          if (e.res_num !== out_data_o.res_num)
            $display("%0t: res_num expected %h actual %h", $time, e.res_num,
                     out_data_o.res_num);
          if (e.res_den !== out_data_o.res_den)
            $display("%0t: res_den expected %h actual %h", $time, e.res_den,
                     out_data_o.res_den);
          if (e.status !== out_data_o.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data_o.status);
          if (e !== out_data_o) errors++;
        end
        recv_gap = pick_gap();
      end
      if (hold_cycles >= 3000 && hold_cycles < 6000) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ready_i <= 1'b0;
        recv_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (stim_done && expected_results.size() == 0);
    repeat (1000) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
